// ===== src/lpft_pkg.sv =====
package lpft_pkg;

    localparam int DEF_MAX_FRAMES = 16;
    localparam int DEF_PAGE_BITS  = 20;

    localparam int CAP_W   = 5;
    localparam int FAULT_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } cmd_t;

endpackage

// ===== src/lpft_if.sv =====
interface lpft_req_if #(
    parameter int PAGE_BITS = lpft_pkg::DEF_PAGE_BITS
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;
    logic                 last;

    modport source (output valid, output page, output last, input ready);
    modport sink   (input valid, input page, input last, output ready);
endinterface

interface lpft_rsp_if #(
    parameter int PAGE_BITS = lpft_pkg::DEF_PAGE_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic                          evicted_valid;
    logic [PAGE_BITS-1:0]          evicted_page;
    logic [lpft_pkg::FAULT_W-1:0]  fault_count;

    modport source (output valid, output hit, output evicted_valid, output evicted_page,
                    output fault_count, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                    input fault_count, output ready);
endinterface

interface lpft_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lpft_pkg::CAP_W-1:0]  capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// ===== src/lpft_ctrl.sv =====
module lpft_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lpft_pkg::cmd_t cmd
);
    import lpft_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   req_ready_reg, req_ready_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        cmd.capture = (state_reg == S_IDLE) && req_valid && req_ready_reg;
        cmd.lookup  = (state_reg == S_LOOKUP);
        cmd.update  = (state_reg == S_UPDATE) && (!rsp_valid_reg || rsp_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        req_ready_next = req_ready_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next     = S_LOOKUP;
                    req_ready_next = 1'b0;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (cmd.update)
                begin
                    state_next     = S_IDLE;
                    req_ready_next = 1'b1;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                req_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_ready_reg <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_ready_reg <= req_ready_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = req_ready_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== src/lpft_datapath.sv =====
module lpft_datapath #(
    parameter int MAX_FRAMES = lpft_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lpft_pkg::DEF_PAGE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpft_pkg::cmd_t                cmd,
    input  logic [PAGE_BITS-1:0]          req_page,
    input  logic                          req_last,
    input  logic                          cfg_we,
    input  logic [lpft_pkg::CAP_W-1:0]    cfg_capacity,
    output logic                          rsp_hit,
    output logic                          rsp_evicted_valid,
    output logic [PAGE_BITS-1:0]          rsp_evicted_page,
    output logic [lpft_pkg::FAULT_W-1:0]  rsp_fault_count
);
    import lpft_pkg::*;

    localparam int AGE_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    logic [CAP_W-1:0]     capacity_reg;

    logic [PAGE_BITS-1:0] page_reg;
    logic                 last_reg;

    logic [PAGE_BITS-1:0] frame_page_reg  [MAX_FRAMES];
    logic [PAGE_BITS-1:0] frame_page_next [MAX_FRAMES];
    logic [AGE_W-1:0]     frame_age_reg   [MAX_FRAMES];
    logic [AGE_W-1:0]     frame_age_next  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] frame_valid_reg, frame_valid_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [FAULT_W-1:0]   faults_reg, faults_next, faults_upd;

    logic                  hit_reg;
    logic                  full_reg;
    logic [MAX_FRAMES-1:0] slot_oh_reg;

    logic [CNT_W-1:0]      cap_eff;
    logic                  full;
    logic [AGE_W-1:0]      last_age;
    logic [MAX_FRAMES-1:0] hit_oh, lru_oh, free_oh, slot_oh;
    logic                  found_hit, found_lru, found_free;

    logic [AGE_W-1:0]      sel_age;
    logic [PAGE_BITS-1:0]  sel_page;
    logic                  ev_valid;

    always_comb
    begin
        if (capacity_reg == '0)
            cap_eff = CNT_W'(1);
        else if (32'(capacity_reg) > 32'(MAX_FRAMES))
            cap_eff = CNT_W'(MAX_FRAMES);
        else
            cap_eff = CNT_W'(capacity_reg);
        full     = (occ_reg >= cap_eff);
        last_age = AGE_W'(occ_reg - CNT_W'(1));

        found_hit  = 1'b0;
        found_lru  = 1'b0;
        found_free = 1'b0;
        hit_oh     = '0;
        lru_oh     = '0;
        free_oh    = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (!found_hit && frame_valid_reg[i] && frame_page_reg[i] == page_reg)
            begin
                hit_oh[i] = 1'b1;
                found_hit = 1'b1;
            end
            if (!found_lru && frame_valid_reg[i] && frame_age_reg[i] == last_age)
            begin
                lru_oh[i] = 1'b1;
                found_lru = 1'b1;
            end
            if (!found_free && !frame_valid_reg[i])
            begin
                free_oh[i] = 1'b1;
                found_free = 1'b1;
            end
        end

        if (found_hit)
            slot_oh = hit_oh;
        else if (full)
            slot_oh = lru_oh;
        else
            slot_oh = free_oh;
    end

    always_comb
    begin
        sel_age  = '0;
        sel_page = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (slot_oh_reg[i])
            begin
                sel_age  = sel_age | frame_age_reg[i];
                sel_page = sel_page | frame_page_reg[i];
            end
        end
        ev_valid = !hit_reg && full_reg;

        if (hit_reg || faults_reg == '1)
            faults_upd = faults_reg;
        else
            faults_upd = faults_reg + FAULT_W'(1);

        frame_valid_next = frame_valid_reg;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            frame_page_next[i] = frame_page_reg[i];
            frame_age_next[i]  = frame_age_reg[i];
            if (slot_oh_reg[i])
            begin
                frame_age_next[i] = '0;
                if (!hit_reg)
                begin
                    frame_valid_next[i] = 1'b1;
                    frame_page_next[i]  = page_reg;
                end
            end
            else if (frame_valid_reg[i] && (!hit_reg || frame_age_reg[i] < sel_age))
            begin
                frame_age_next[i] = AGE_W'(frame_age_reg[i] + 1'b1);
            end
        end

        occ_next    = (!hit_reg && !full_reg) ? CNT_W'(occ_reg + 1'b1) : occ_reg;
        faults_next = faults_upd;
        if (last_reg)
        begin
            frame_valid_next = '0;
            occ_next         = '0;
            faults_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= CAP_RESET;
            frame_valid_reg <= '0;
            occ_reg         <= '0;
            faults_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_capacity;
            if (cmd.update)
            begin
                frame_valid_reg <= frame_valid_next;
                occ_reg         <= occ_next;
                faults_reg      <= faults_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg <= req_page;
            last_reg <= req_last;
        end
        if (cmd.lookup)
        begin
            hit_reg     <= found_hit;
            full_reg    <= full;
            slot_oh_reg <= slot_oh;
        end
        if (cmd.update)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                frame_page_reg[i] <= frame_page_next[i];
                frame_age_reg[i]  <= frame_age_next[i];
            end
            rsp_hit           <= hit_reg;
            rsp_evicted_valid <= ev_valid;
            rsp_evicted_page  <= ev_valid ? sel_page : '0;
            rsp_fault_count   <= faults_upd;
        end
    end

endmodule

// ===== src/lru_page_fault_tracker_core.sv =====
// LRU page fault tracker: fully associative page table with LRU replacement.
// req channel: one beat per page reference (page, last). rsp channel: one beat
// per reference (hit, evicted_valid, evicted_page, fault_count). cfg channel:
// one beat writes the capacity register (frames in use); it is always ready.
// The user must write it only while no reference is in flight (unenforced).
// Timing: a reference is accepted in the idle state, the lookup cycle compares
// it against every frame in parallel and registers the chosen frame, and the
// update cycle rewrites the frame ages and loads the response register.
// The response register loads in the update cycle, after the lookup cycle; a
// new reference is taken only once the update for the last one is done.
// A pending response may sit in its register while the next reference is
// accepted and looked up; if the receiver still stalls, the update cycle
// holds until the response register frees, and req stays not ready.
// Reset: table empty, fault count zero, capacity 16, req ready, rsp idle.
// A beat with last set clears the table and fault count after its response.
module lru_page_fault_tracker_core #(
    parameter int MAX_FRAMES = lpft_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lpft_pkg::DEF_PAGE_BITS
) (
    input logic      clk,
    input logic      rst_n,
    lpft_req_if.sink   req,
    lpft_rsp_if.source rsp,
    lpft_cfg_if.sink   cfg
);
    import lpft_pkg::*;

    cmd_t cmd;

    assign cfg.ready = 1'b1;

    lpft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    lpft_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .req_page          (req.page),
        .req_last          (req.last),
        .cfg_we            (cfg.valid),
        .cfg_capacity      (cfg.capacity),
        .rsp_hit           (rsp.hit),
        .rsp_evicted_valid (rsp.evicted_valid),
        .rsp_evicted_page  (rsp.evicted_page),
        .rsp_fault_count   (rsp.fault_count)
    );

endmodule
